>>> rtl/rcle_pkg.sv
package rcle_pkg;

    localparam int unsigned ALPHA     = 26;
    localparam int unsigned TABLES    = 4;             // three rotors and the reflector
    localparam int unsigned MEM_DEPTH = TABLES * ALPHA;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
    localparam int unsigned PAIRS     = 5;             // plug pairs per config register
    localparam int unsigned PAIR_W    = 10;
    localparam int unsigned PLUG_W    = PAIRS * PAIR_W;
    localparam int unsigned NOTCH_W   = 15;

    localparam logic [7:0] ASCII_A  = 8'h41;
    localparam logic [7:0] ASCII_Z  = 8'h5a;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7a;
    localparam logic [7:0] ASCII_0  = 8'h30;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] KIND_ENCODE = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_SETPOS = 2'd2;

    localparam logic [1:0] TBL_REFLECTOR = 2'd3;

    localparam logic [1:0] CFG_PLUG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_PLUG_SECOND = 2'd1;
    localparam logic [1:0] CFG_NOTCH       = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LETTER = 2'd1;
    localparam logic [1:0] ST_NO_INVERSE = 2'd2;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [4:0]        data;
    } t_mem_wr;

    function automatic logic [4:0] mod26(input logic [5:0] v);
        logic [5:0] d;
        d = v - 6'(ALPHA);
        return (v >= 6'(ALPHA)) ? d[4:0] : v[4:0];
    endfunction

    // first address of a wiring table in the shared memory
    function automatic logic [MEM_AW-1:0] table_base(input logic [1:0] t);
        return MEM_AW'({30'd0, t} * ALPHA);
    endfunction

endpackage

>>> rtl/rcle_wiring_mem.sv
module rcle_wiring_mem
    import rcle_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  logic [MEM_AW-1:0] i_rd_addr,
    output logic [4:0]        o_rd_data
);

    logic [4:0] r_mem [MEM_DEPTH];
    logic [4:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

>>> rtl/rcle_plugboard.sv
module rcle_plugboard
    import rcle_pkg::*;
(
    input  logic [PLUG_W-1:0] i_pairs_first,
    input  logic [PLUG_W-1:0] i_pairs_second,
    input  logic [4:0]        i_x,
    output logic [4:0]        o_y
);

    logic [2*PLUG_W-1:0] pairs;
    logic [4:0]          a;
    logic [4:0]          b;

    assign pairs = {i_pairs_second, i_pairs_first};

    // walk from the highest pair down so the lowest matching pair wins
    always_comb begin
        o_y = i_x;
        a   = '0;
        b   = '0;
        for (int k = 2 * PAIRS - 1; k >= 0; k--) begin
            a = pairs[k*PAIR_W +: 5];
            b = pairs[k*PAIR_W + 5 +: 5];
            if (a < 5'(ALPHA) && b < 5'(ALPHA)) begin
                if (i_x == a) begin
                    o_y = b;
                end else if (i_x == b) begin
                    o_y = a;
                end
            end
        end
    end

endmodule

>>> rtl/rotor_cipher_letter_encoder_unit.sv
// Three-rotor letter cipher with one shared wiring memory (rotors 0-2 and the
// reflector, 104 five-bit entries, one registered read per cycle). A wiring
// write, a position set or a rejected byte goes from idle straight to the done
// state and then into the output register. An encode walks the memory: the
// forward path through three rotors and the reflector, then an inverse search
// per rotor that reads one entry a cycle and ends at the match or after the last
// entry, then the plugboard and the result. The inverse search on the single
// read port sets the length of an encode. Wiring entries must be written before
// an encode reads them. A finished result waits in an output register while the
// next transaction is taken.
module rotor_cipher_letter_encoder_unit
    import rcle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [49:0]   i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_letter_in,
    input  logic [1:0]    i_table_select,
    input  logic [4:0]    i_entry_index,
    input  logic [4:0]    i_entry_value,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_letter_out,
    output logic [1:0]    o_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FADDR = 3'd1;
    localparam logic [2:0] S_FDATA = 3'd2;
    localparam logic [2:0] S_BACK  = 3'd3;
    localparam logic [2:0] S_PLUG  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state;
    logic [1:0]          r_rot;
    logic [4:0]          r_idx;
    logic                r_chk_v;
    logic [4:0]          r_chk_idx;
    logic [4:0]          r_x;
    logic [4:0]          r_pos [3];
    logic [PLUG_W-1:0]   r_plug_first;
    logic [PLUG_W-1:0]   r_plug_second;
    logic [NOTCH_W-1:0]  r_notch;
    logic [7:0]          r_res_letter;
    logic [1:0]          r_res_status;
    logic                r_out_valid;
    logic [7:0]          r_out_letter;
    logic [1:0]          r_out_status;

    logic                in_accept;
    logic                out_load;
    logic [7:0]          upper;
    logic                is_letter;
    logic [7:0]          letter_ofs;
    logic [4:0]          eval;
    logic [4:0]          cur_pos;
    logic [MEM_AW-1:0]   base;
    logic [MEM_AW-1:0]   rd_addr;
    logic [4:0]          rd_data;
    logic [4:0]          plug_in;
    logic [4:0]          plug_out;
    logic [4:0]          back_res;
    logic [4:0]          n_pos [3];
    t_mem_wr             mem_wr;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        upper = i_letter_in;
        if (i_letter_in inside {[ASCII_LA:ASCII_LZ]}) begin
            upper = i_letter_in - CASE_OFS;
        end
        is_letter  = upper inside {[ASCII_A:ASCII_Z]};
        letter_ofs = upper - ASCII_A;
    end

    assign eval = mod26({1'b0, i_entry_value});

    always_comb begin
        case (r_rot)
            2'd0:    cur_pos = r_pos[0];
            2'd1:    cur_pos = r_pos[1];
            2'd2:    cur_pos = r_pos[2];
            default: cur_pos = '0;
        endcase
    end

    assign base = table_base(r_rot);

    always_comb begin
        if (r_state == S_BACK) begin
            rd_addr = base + MEM_AW'(r_idx);
        end else begin
            rd_addr = base + MEM_AW'(mod26({1'b0, r_x} + {1'b0, cur_pos}));
        end
    end

    assign back_res = mod26({1'b0, r_chk_idx} + 6'(ALPHA) - {1'b0, cur_pos});

    always_comb begin
        mem_wr.en   = in_accept && (i_kind == KIND_WRITE) && (i_entry_index < 5'(ALPHA));
        mem_wr.addr = table_base(i_table_select) + MEM_AW'(i_entry_index);
        mem_wr.data = eval;
    end

    assign plug_in = (r_state == S_IDLE) ? letter_ofs[4:0] : r_x;

    // odometer step: a rotor carries when it lands on its notch
    always_comb begin
        n_pos[0] = mod26({1'b0, r_pos[0]} + 6'd1);
        n_pos[1] = r_pos[1];
        n_pos[2] = r_pos[2];
        if (n_pos[0] == r_notch[4:0]) begin
            n_pos[1] = mod26({1'b0, r_pos[1]} + 6'd1);
            if (n_pos[1] == r_notch[9:5]) begin
                n_pos[2] = mod26({1'b0, r_pos[2]} + 6'd1);
            end
        end
    end

    rcle_wiring_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rcle_plugboard u_plug (
        .i_pairs_first  (r_plug_first),
        .i_pairs_second (r_plug_second),
        .i_x            (plug_in),
        .o_y            (plug_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug_first  <= '0;
            r_plug_second <= '0;
            r_notch       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLUG_FIRST:  r_plug_first  <= i_cfg_data[PLUG_W-1:0];
                CFG_PLUG_SECOND: r_plug_second <= i_cfg_data[PLUG_W-1:0];
                CFG_NOTCH:       r_notch       <= i_cfg_data[NOTCH_W-1:0];
                default:         ;
            endcase
        end
    end

    // output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid  <= 1'b1;
            r_out_letter <= r_res_letter;
            r_out_status <= r_res_status;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rot       <= '0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pos[2]    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (i_kind)
                            KIND_ENCODE: begin
                                if (is_letter) begin
                                    r_x     <= plug_out;
                                    r_rot   <= '0;
                                    r_state <= S_FADDR;
                                end else begin
                                    r_res_letter <= '0;
                                    r_res_status <= ST_NOT_LETTER;
                                    r_state      <= S_DONE;
                                end
                            end
                            KIND_SETPOS: begin
                                r_res_letter <= '0;
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                                case (i_table_select)
                                    2'd0:    r_pos[0] <= eval;
                                    2'd1:    r_pos[1] <= eval;
                                    2'd2:    r_pos[2] <= eval;
                                    default: ;
                                endcase
                            end
                            default: begin
                                r_res_letter <= '0;
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FADDR: begin
                    r_state <= S_FDATA;
                end
                S_FDATA: begin
                    r_x <= rd_data;
                    if (r_rot == TBL_REFLECTOR) begin
                        r_rot   <= 2'd2;
                        r_idx   <= '0;
                        r_chk_v <= 1'b0;
                        r_state <= S_BACK;
                    end else begin
                        r_rot   <= r_rot + 2'd1;
                        r_state <= S_FADDR;
                    end
                end
                S_BACK: begin
                    if (r_chk_v && rd_data == r_x) begin
                        r_x     <= back_res;
                        r_idx   <= '0;
                        r_chk_v <= 1'b0;
                        if (r_rot == 2'd0) begin
                            r_state <= S_PLUG;
                        end else begin
                            r_rot <= r_rot - 2'd1;
                        end
                    end else if (r_chk_v && r_chk_idx == 5'(ALPHA - 1)) begin
                        // no inverse: report it, rotors still advance
                        r_res_letter <= ASCII_0;
                        r_res_status <= ST_NO_INVERSE;
                        r_pos        <= n_pos;
                        r_state      <= S_DONE;
                    end else begin
                        r_chk_v   <= 1'b1;
                        r_chk_idx <= r_idx;
                        r_idx     <= r_idx + 5'd1;
                    end
                end
                S_PLUG: begin
                    r_res_letter <= 8'(plug_out) + ASCII_A;
                    r_res_status <= ST_OK;
                    r_pos        <= n_pos;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_letter_out = r_out_letter;
    assign o_status     = r_out_status;

endmodule

>>> rtl/rcle_checker.sv
module rcle_checker
    import rcle_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_kind,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_letter_out,
    input logic [1:0] o_status
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_letter_out)
            && $stable(o_status))
        else $error("result dropped or changed while stalled");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NOT_LETTER |-> o_letter_out == 8'h00)
        else $error("rejected byte produced a letter");

    a_no_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NO_INVERSE |-> o_letter_out == ASCII_0)
        else $error("failed inverse without the fallback letter");

    a_ok_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |->
            o_letter_out == 8'h00 || (o_letter_out >= ASCII_A && o_letter_out <= ASCII_Z))
        else $error("ok result is not an upper-case letter");

    // an accepted encode takes the unit out of idle, so ready drops
    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind == KIND_ENCODE |=> !o_in_ready)
        else $error("ready returned right after an encode");

endmodule

bind rotor_cipher_letter_encoder_unit rcle_checker u_rcle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_letter_out (o_letter_out),
    .o_status     (o_status)
);
